### design/bffa_pkg.sv
`timescale 1ns / 1ps

package bffa_pkg;

  // Default geometry of the frame bitmap
  localparam int FRAME_COUNT_DEF = 65536;
  localparam int WORD_BITS_DEF   = 64;

  // Frame arithmetic width: holds a start plus a length without overflow
  localparam int FRAME_W   = 18;
  // Highest frame count that request fields can reach
  localparam int FRAME_CAP = 131072;

  // Request operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_NOSPACE = 1'b1;

  // Configuration register indexes (word address bit)
  localparam logic REG_RANGE_FIRST = 1'b0;
  localparam logic REG_RANGE_LIMIT = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] run_start;
    logic [16:0] run_length;
  } bffa_req_t;

  typedef struct packed {
    logic        status;
    logic [15:0] first_frame;
  } bffa_rsp_t;

endpackage

### design/bffa_ram.sv
`timescale 1ns / 1ps

module bffa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/bffa_div.sv
`timescale 1ns / 1ps

module bffa_div #(
  parameter int DW      = 18,
  parameter int DIVISOR = 64,
  parameter int RW      = $clog2(DIVISOR + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [RW-1:0] rem_o
);

  // Reciprocal constants: (dividend * MUL) >> SH gives the exact quotient of any DW-bit value
  localparam int              LW    = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
  localparam int              SH    = DW + LW;
  localparam longint unsigned MUL   = ((longint'(1) << SH) + DIVISOR - 1) / DIVISOR;
  localparam int              MW    = DW + 2;
  localparam logic [MW-1:0]   MUL_C = MW'(MUL);
  localparam logic [DW-1:0]   DIV_C = DW'(DIVISOR);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_REM  = 2'd2;

  logic [1:0]       ph_q, ph_d;
  logic             done_q, done_d;
  logic [DW-1:0]    dvd_q, dvd_d;
  logic [DW-1:0]    quot_q, quot_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [DW+MW-1:0] prod;
  logic [DW-1:0]    back;

  // Quotient by reciprocal multiply, then remainder by multiply and subtract
  always_comb begin
    ph_d   = ph_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    prod   = dvd_q * MUL_C;
    back   = DW'(quot_q * DIV_C);
    if (start_i) begin
      ph_d  = PH_MUL;
      dvd_d = dividend_i;
    end else begin
      case (ph_q)
        PH_MUL: begin
          quot_d = DW'(prod >> SH);
          ph_d   = PH_REM;
        end
        PH_REM: begin
          rem_d  = RW'(dvd_q - back);
          done_d = 1'b1;
          ph_d   = PH_IDLE;
        end
        default: begin
          ph_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

### design/bffa_win.sv
`timescale 1ns / 1ps

module bffa_win #(
  parameter int W  = 64,
  parameter int BW = $clog2(W + 1)
) (
  input  logic [W-1:0]  word_i,
  input  logic [BW-1:0] bit_i,
  input  logic [BW-1:0] len_i,
  input  logic          set_i,
  output logic          hit_o,
  output logic [BW-1:0] next_o,
  output logic [W-1:0]  word_o
);

  localparam logic [BW-1:0] W_BW = BW'(W);

  logic [W-1:0]  ones;
  logic [BW-1:0] sh;
  logic [W-1:0]  mask;
  logic [W-1:0]  used;

  // Build the window mask over bits [bit, bit + len)
  always_comb begin
    ones = '1;
    sh   = W_BW - len_i;
    mask = (ones >> sh) << bit_i;
    used = word_i & mask;
  end

  // Find the highest used bit in the window, report the bit after it
  always_comb begin
    next_o = '0;
    for (int j = 0; j < W; j++) begin
      if (used[j]) begin
        next_o = BW'(j + 1);
      end
    end
  end

  assign hit_o  = |used;
  assign word_o = set_i ? (word_i | mask) : (word_i & ~mask);

endmodule

### design/bitmap_first_fit_frame_allocator.sv
`timescale 1ns / 1ps
// Channel   Handshake                        Payload
// request   start (in), busy (out)           req_i  : op, run_start, run_length
// result    rsp_valid_o (one-cycle strobe)   rsp_o  : status, first_frame
// config    APB psel/penable/pwrite/pready   paddr, pwdata, prdata (range_first, range_limit)
//
// A request is taken when start is high and busy is low; one result follows per request.
// Zero-length requests and requests that fail at once answer in the next cycle.
// Otherwise a request first goes through the shared divider (frame to word/bit),
// then the scan reads bitmap words (a skip past a used bit re-reads its word), and
// each word is read and written back when the run is marked or freed.
// After reset the bitmap RAM is cleared one word per cycle (1024 words by default).
// The result strobe cannot be stalled; busy stays low while it is shown.

module bitmap_first_fit_frame_allocator #(
  parameter int FRAME_COUNT = bffa_pkg::FRAME_COUNT_DEF,
  parameter int WORD_BITS   = bffa_pkg::WORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bffa_pkg::bffa_req_t req_i,
  output logic                rsp_valid_o,
  output bffa_pkg::bffa_rsp_t rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import bffa_pkg::*;

  localparam int PW      = FRAME_W;
  localparam int FC_CLIP = (FRAME_COUNT < FRAME_CAP) ? FRAME_COUNT : FRAME_CAP;
  localparam int DEPTH   = (FC_CLIP + WORD_BITS - 1) / WORD_BITS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW      = $clog2(WORD_BITS + 1);

  localparam logic [PW-1:0] FC_LIM = PW'(FC_CLIP);
  localparam logic [BW-1:0] W_BW   = BW'(WORD_BITS);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SRD  = 3'd3;
  localparam logic [2:0] S_SCHK = 3'd4;
  localparam logic [2:0] S_MRD  = 3'd5;
  localparam logic [2:0] S_MWR  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic          op_free_q, op_free_d;
  logic [PW-1:0] cand_q, cand_d;
  logic [AW-1:0] cand_w_q, cand_w_d;
  logic [BW-1:0] cand_b_q, cand_b_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [AW-1:0] pos_w_q, pos_w_d;
  logic [BW-1:0] pos_b_q, pos_b_d;
  logic [16:0]   len_q, len_d;
  logic [PW-1:0] lim_q, lim_d;
  logic [PW-1:0] end_q, end_d;
  logic [BW-1:0] n_q, n_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [16:0]   range_first_q;
  logic [16:0]   range_limit_q;
  logic          rsp_valid_q, rsp_valid_d;
  bffa_rsp_t     rsp_q, rsp_d;

  logic                 cfg_wr;
  logic                 div_start;
  logic [PW-1:0]        div_dvd;
  logic                 div_done;
  logic [PW-1:0]        div_quot;
  logic [BW-1:0]        div_rem;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WORD_BITS-1:0] ram_rdata;
  logic                 win_hit;
  logic [BW-1:0]        win_next;
  logic [WORD_BITS-1:0] win_word;

  logic [PW-1:0] lim_new;
  logic [PW-1:0] free_sum;
  logic [PW-1:0] free_end;
  logic [PW-1:0] cand_len;
  logic [PW-1:0] scan_end;
  logic [PW-1:0] tgt;
  logic [PW-1:0] left;
  logic [BW-1:0] w_left;
  logic [BW-1:0] n_new;
  logic [BW-1:0] step_b;
  logic [PW-1:0] step_pos;
  logic [AW-1:0] step_w;
  logic [BW-1:0] step_bit;

  // Configuration registers
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RANGE_LIMIT) ? 32'(range_limit_q) : 32'(range_first_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_first_q <= 17'h00000;
      range_limit_q <= 17'h10000;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_RANGE_LIMIT) begin
        range_limit_q <= pwdata[16:0];
      end else begin
        range_first_q <= pwdata[16:0];
      end
    end
  end

  // Shared units: frame-to-word divider, bitmap RAM, window mask unit
  bffa_div #(
    .DW      (PW),
    .DIVISOR (WORD_BITS),
    .RW      (BW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  bffa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pos_w_q),
    .rdata_o (ram_rdata)
  );

  bffa_win #(
    .W  (WORD_BITS),
    .BW (BW)
  ) u_win (
    .word_i (ram_rdata),
    .bit_i  (pos_b_q),
    .len_i  (n_q),
    .set_i  (!op_free_q),
    .hit_o  (win_hit),
    .next_o (win_next),
    .word_o (win_word)
  );

  // Request-side bounds
  always_comb begin
    lim_new  = (PW'(range_limit_q) < FC_LIM) ? PW'(range_limit_q) : FC_LIM;
    free_sum = PW'(req_i.run_start) + PW'(req_i.run_length);
    free_end = (free_sum < FC_LIM) ? free_sum : FC_LIM;
    div_dvd  = (req_i.op == OP_FREE) ? PW'(req_i.run_start) : PW'(range_first_q);
  end

  // Window length for the word at pos: up to the scan or mark end, within the word
  always_comb begin
    cand_len = cand_q + PW'(len_q);
    scan_end = (cand_len < lim_q) ? cand_len : lim_q;
    tgt      = (state_q == S_SRD) ? scan_end : end_q;
    left     = tgt - pos_q;
    w_left   = W_BW - pos_b_q;
    n_new    = (left < PW'(w_left)) ? left[BW-1:0] : w_left;
  end

  // Move pos to a new bit of the current word, wrapping into the next word
  always_comb begin
    step_b   = (state_q == S_SCHK && win_hit) ? win_next : (pos_b_q + n_q);
    step_pos = pos_q - PW'(pos_b_q) + PW'(step_b);
    if (step_b == W_BW) begin
      step_w   = pos_w_q + AW'(1);
      step_bit = '0;
    end else begin
      step_w   = pos_w_q;
      step_bit = step_b;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_free_d   = op_free_q;
    cand_d      = cand_q;
    cand_w_d    = cand_w_q;
    cand_b_d    = cand_b_q;
    pos_d       = pos_q;
    pos_w_d     = pos_w_q;
    pos_b_d     = pos_b_q;
    len_d       = len_q;
    lim_d       = lim_q;
    end_d       = end_q;
    n_d         = n_q;
    clr_d       = clr_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    div_start   = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = pos_w_q;
    ram_wdata   = win_word;
    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          len_d     = req_i.run_length;
          op_free_d = (req_i.op == OP_FREE);
          if (req_i.op == OP_FREE) begin
            if (PW'(req_i.run_start) >= free_end) begin
              rsp_valid_d       = 1'b1;
              rsp_d.status      = ST_OK;
              rsp_d.first_frame = '0;
            end else begin
              end_d     = free_end;
              pos_d     = div_dvd;
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end else if (req_i.run_length == '0) begin
            rsp_valid_d       = 1'b1;
            rsp_d.status      = ST_OK;
            rsp_d.first_frame = range_first_q[15:0];
          end else if (PW'(range_first_q) >= lim_new) begin
            rsp_valid_d       = 1'b1;
            rsp_d.status      = ST_NOSPACE;
            rsp_d.first_frame = '0;
          end else begin
            lim_d     = lim_new;
            cand_d    = div_dvd;
            pos_d     = div_dvd;
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          pos_w_d  = div_quot[AW-1:0];
          pos_b_d  = div_rem;
          cand_w_d = div_quot[AW-1:0];
          cand_b_d = div_rem;
          state_d  = op_free_q ? S_MRD : S_SRD;
        end
      end
      S_SRD: begin
        if (pos_q == cand_len) begin
          // whole run free: go mark it
          end_d   = cand_len;
          pos_d   = cand_q;
          pos_w_d = cand_w_q;
          pos_b_d = cand_b_q;
          state_d = S_MRD;
        end else if (pos_q >= lim_q) begin
          rsp_valid_d       = 1'b1;
          rsp_d.status      = ST_NOSPACE;
          rsp_d.first_frame = '0;
          state_d           = S_IDLE;
        end else begin
          n_d     = n_new;
          ram_re  = 1'b1;
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        pos_d   = step_pos;
        pos_w_d = step_w;
        pos_b_d = step_bit;
        if (win_hit) begin
          // restart the run just past the highest used frame in the window
          cand_d   = step_pos;
          cand_w_d = step_w;
          cand_b_d = step_bit;
        end
        state_d = S_SRD;
      end
      S_MRD: begin
        if (pos_q >= end_q) begin
          rsp_valid_d       = 1'b1;
          rsp_d.status      = ST_OK;
          rsp_d.first_frame = op_free_q ? 16'h0000 : cand_q[15:0];
          state_d           = S_IDLE;
        end else begin
          n_d     = n_new;
          ram_re  = 1'b1;
          state_d = S_MWR;
        end
      end
      S_MWR: begin
        ram_we  = 1'b1;
        pos_d   = step_pos;
        pos_w_d = step_w;
        pos_b_d = step_bit;
        state_d = S_MRD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      op_free_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      op_free_q   <= op_free_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q   <= cand_d;
    cand_w_q <= cand_w_d;
    cand_b_q <= cand_b_d;
    pos_q    <= pos_d;
    pos_w_q  <= pos_w_d;
    pos_b_q  <= pos_b_d;
    len_q    <= len_d;
    lim_q    <= lim_d;
    end_q    <= end_d;
    n_q      <= n_d;
    rsp_q    <= rsp_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // A result is only shown once the sequencer is back at rest
  a_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (state_q == S_IDLE))
    else $error("result strobe while a request is still in progress");

  // The scan candidate never moves backward
  a_cand_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCHK) |=> (cand_q >= $past(cand_q)))
    else $error("scan candidate moved backward");

  // The bit offset stays inside a word while the bitmap is walked
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRD || state_q == S_SCHK || state_q == S_MRD || state_q == S_MWR)
      |-> (pos_b_q < W_BW))
    else $error("bit offset outside the word");

  // The window length is never empty when a word is examined or written
  a_win_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCHK || state_q == S_MWR) |-> (n_q != '0))
    else $error("empty window on a bitmap word");

endmodule

### bench/bitmap_first_fit_frame_allocator_tb.sv
`timescale 1ns / 1ps

module bitmap_first_fit_frame_allocator_tb;
  import bffa_pkg::*;

  localparam int unsigned FRAMES = FRAME_COUNT_DEF;
  localparam int unsigned WATCHDOG_CYCLES = 400000;
  localparam logic [2:0] ADDR_RANGE_FIRST = {REG_RANGE_FIRST, 2'b00};
  localparam logic [2:0] ADDR_RANGE_LIMIT = {REG_RANGE_LIMIT, 2'b00};

  typedef struct {
    int unsigned base;
    int unsigned span;
  } held_run_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  bffa_req_t   req_bus = '0;
  logic        rsp_valid_o;
  bffa_rsp_t   rsp_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Request bookkeeping shared by driver, monitor and stimulus
  bffa_req_t   pending_req_q[$];
  bffa_rsp_t   awaited_rsp_q[$];
  held_run_t   held_runs[$];
  bffa_req_t   taken_req = '0;
  logic        req_taken = 1'b0;
  bffa_rsp_t   want_rsp;
  int          sender_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  // Shadow of the frame bitmap and the range registers
  bit          frame_used [FRAMES];
  int unsigned range_first_cfg = 0;
  int unsigned range_limit_cfg = 65536;

  bitmap_first_fit_frame_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_bus),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Apply one request to the shadow bitmap and return the result it must give
  function automatic bffa_rsp_t first_fit_outcome(input bffa_req_t r);
    bffa_rsp_t   res;
    int unsigned len, lim, cand, i, f;
    bit          placed, failed;
    held_run_t   run;
    res = '0;
    res.status = ST_OK;
    len = r.run_length;
    if (r.op == OP_FREE) begin
      // clear the run, drop frames past the store
      for (i = 0; i < len; i++) begin
        f = r.run_start + i;
        if (f < FRAMES) frame_used[f] = 1'b0;
      end
    end else begin
      lim = (range_limit_cfg > FRAMES) ? FRAMES : range_limit_cfg;
      cand = range_first_cfg;
      placed = 1'b0;
      failed = 1'b0;
      // advance the candidate past each used frame that blocks it
      while (!placed && !failed) begin
        i = 0;
        while (i < len && cand + i < lim && !frame_used[cand + i]) i++;
        if (i == len) placed = 1'b1;
        else if (cand + i >= lim) failed = 1'b1;
        else cand = cand + i + 1;
      end
      if (failed) begin
        res.status = ST_NOSPACE;
      end else begin
        for (i = 0; i < len; i++) frame_used[cand + i] = 1'b1;
        res.first_frame = cand[15:0];
        if (len != 0) begin
          run.base = cand;
          run.span = len;
          held_runs.push_back(run);
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input bffa_rsp_t want, input bffa_rsp_t got);
    if (mismatch_count < 10)
      $display("%0t %s: expected status %0d first_frame %0d, got status %0d first_frame %0d",
               $time, what, want.status, want.first_frame, got.status, got.first_frame);
    mismatch_count++;
  endtask

  // Driver: hold a request until the block takes it, idle at random between requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
      if (start && !busy) begin
        taken_req <= req_bus;
        pending_req_q.delete(0);
        if (pending_req_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          req_bus <= pending_req_q[0];
        end else begin
          start <= 1'b0;
        end
      end else if (!start && pending_req_q.size() != 0 &&
                   $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        req_bus <= pending_req_q[0];
      end
    end
  end

  // Monitor: predict taken requests, check each result strobe, watch for a hang
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (req_taken) awaited_rsp_q.push_back(first_fit_outcome(taken_req));
      if (rsp_valid_o === 1'b1) begin
        if (awaited_rsp_q.size() == 0) begin
          report_mismatch("unexpected result", '0, rsp_o);
        end else begin
          want_rsp = awaited_rsp_q.pop_front();
          if (rsp_o.status !== want_rsp.status || rsp_o.first_frame !== want_rsp.first_frame)
            report_mismatch("wrong result", want_rsp, rsp_o);
        end
      end
      if ((start && !busy) || rsp_valid_o === 1'b1 || (psel && penable && pwrite && pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles < WATCHDOG_CYCLES) begin
        idle_cycles <= idle_cycles + 1;
      end else begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Queue one request, keeping at most two ahead of the driver
  task automatic queue_request(input logic op, input int unsigned run_start,
                               input int unsigned run_length);
    bffa_req_t r;
    r.op = op;
    r.run_start = run_start[15:0];
    r.run_length = run_length[16:0];
    while (pending_req_q.size() >= 2) @(negedge clk_i);
    pending_req_q.push_back(r);
  endtask

  // Hold the sender until every request has been answered
  task automatic wait_drained();
    while (pending_req_q.size() != 0 || start || req_taken || awaited_rsp_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_RANGE_FIRST) range_first_cfg = data[16:0];
    else range_limit_cfg = data[16:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One random phase: set the search window, then mix allocates and frees
  task automatic random_phase(input int idle_pct, input logic [31:0] first_word,
                              input logic [31:0] limit_word, input int unsigned items,
                              input int unsigned max_len);
    int unsigned lo, hi, win_span, n, pick, len, idx, off, cnt, at;
    held_run_t   run;
    wait_drained();
    write_reg(ADDR_RANGE_FIRST, first_word | ($urandom_range(1) ? ($urandom << 17) : 32'd0));
    write_reg(ADDR_RANGE_LIMIT, limit_word);
    sender_idle_pct = idle_pct;
    lo = first_word[16:0];
    hi = (limit_word[16:0] > FRAMES) ? FRAMES : limit_word[16:0];
    win_span = (hi > lo) ? hi - lo : 1;
    for (n = 0; n < items; n++) begin
      if ($urandom_range(29) == 0) wait_drained();
      pick = $urandom_range(99);
      if (pick < 50) begin
        // allocate: mostly short runs, some long enough to fail
        case ($urandom_range(19))
          0: len = 0;
          1, 2: len = $urandom_range(1, max_len);
          default: len = $urandom_range(1, (max_len < 16) ? max_len : 16);
        endcase
        queue_request(OP_ALLOC, $urandom_range(0, 65535), len);
      end else if (pick < 85 && held_runs.size() != 0) begin
        // free a run handed out earlier, sometimes only part of it
        idx = $urandom_range(0, held_runs.size() - 1);
        run = held_runs[idx];
        held_runs.delete(idx);
        if ($urandom_range(3) == 0) begin
          off = $urandom_range(0, run.span - 1);
          cnt = $urandom_range(1, run.span - off);
          queue_request(OP_FREE, run.base + off, cnt);
        end else begin
          queue_request(OP_FREE, run.base, run.span);
        end
      end else begin
        // stray frees: inside the window, anywhere, or rarely huge
        if ($urandom_range(49) == 0) begin
          queue_request(OP_FREE, $urandom_range(0, 65535), $urandom_range(0, 131071));
        end else begin
          at = $urandom_range(1) ? lo + $urandom_range(0, win_span - 1) : $urandom_range(0, 65535);
          queue_request(OP_FREE, at, $urandom_range(0, 32));
        end
      end
    end
  endtask

  // Stimulus
  initial begin
    int unsigned lo;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed requests on the reset window
    sender_idle_pct = 0;
    queue_request(OP_ALLOC, 0, 0);
    queue_request(OP_ALLOC, 16'hFFFF, 1);
    queue_request(OP_ALLOC, 0, 65536);
    queue_request(OP_FREE, 0, 1);
    queue_request(OP_ALLOC, 0, 65536);
    queue_request(OP_FREE, 0, 65536);
    queue_request(OP_ALLOC, 0, 3);
    queue_request(OP_ALLOC, 0, 5);
    queue_request(OP_FREE, 1, 1);
    queue_request(OP_ALLOC, 0, 2);
    queue_request(OP_ALLOC, 0, 1);
    queue_request(OP_FREE, 100, 5);
    queue_request(OP_FREE, 0, 0);
    queue_request(OP_ALLOC, 0, 131071);
    queue_request(OP_FREE, 65535, 131071);
    queue_request(OP_FREE, 0, 16);
    wait_drained();

    // empty window at the top of the range
    write_reg(ADDR_RANGE_FIRST, 32'd65536);
    write_reg(ADDR_RANGE_LIMIT, 32'd65536);
    queue_request(OP_ALLOC, 0, 0);
    queue_request(OP_ALLOC, 0, 1);
    wait_drained();

    // inverted window
    write_reg(ADDR_RANGE_FIRST, 32'd1000);
    write_reg(ADDR_RANGE_LIMIT, 32'd10);
    queue_request(OP_ALLOC, 0, 0);
    queue_request(OP_ALLOC, 0, 1);
    wait_drained();

    // limit past the store
    write_reg(ADDR_RANGE_FIRST, 32'd65530);
    write_reg(ADDR_RANGE_LIMIT, 32'h0001_FFFF);
    queue_request(OP_ALLOC, 0, 6);
    queue_request(OP_ALLOC, 0, 1);
    queue_request(OP_FREE, 65530, 6);
    queue_request(OP_ALLOC, 0, 7);

    // random phases over windows of several sizes and sender idling
    random_phase(0, 32'd0, 32'd65536, 80, 256);
    lo = $urandom_range(0, 65536 - 256);
    random_phase(47, lo, lo + 256, 80, 264);
    random_phase(10, 32'd65024, 32'hFFFF_FFFF, 70, 520);
    lo = $urandom_range(0, 65536 - 2048);
    random_phase(0, lo, lo + 2048, 80, 2056);
    lo = $urandom_range(1, 65536 - 64);
    random_phase(47, lo, lo + 64, 70, 72);
    queue_request(OP_FREE, 0, 65536);
    lo = $urandom_range(0, 65536 - 1024);
    random_phase(10, lo, lo + 1024, 70, 1032);
    lo = $urandom_range(0, 65536 - 4096);
    random_phase(0, lo, lo + 4096, 80, 4104);
    random_phase(47, 32'd40000, 32'd30000, 50, 16);

    // drain, then leave room for any stray result
    wait_drained();
    repeat (50) @(negedge clk_i);
    if (mismatch_count == 0 && awaited_rsp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### bitmap_first_fit_frame_allocator.f
design/bffa_pkg.sv
design/bffa_ram.sv
design/bffa_div.sv
design/bffa_win.sv
design/bitmap_first_fit_frame_allocator.sv
bench/bitmap_first_fit_frame_allocator_tb.sv
